FILE: sv/frs_pkg.sv
// Shared types and constants of the Fenwick rank/select set.
// Holds the operation codes and the request and result records; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package frs_pkg;

    localparam int KEY_W  = 10;          // width of a key slot
    localparam int CNT_W  = 11;          // width of a count or an order
    localparam int WORD_W = CNT_W + 1;   // memory word: presence bit over tree count

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_COUNT  = 2'd2,
        FN_SELECT = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key_slot;
        logic [CNT_W-1:0]   order_k;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]   below_count;
        logic [KEY_W-1:0]   found_slot;
        logic               invalid;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/frs_mem.sv
// Simple dual-port synchronous RAM with a registered read port.
// Stand-alone; used by the sequencer to hold presence bits and tree counts.
`timescale 1ns / 1ps
`default_nettype none

module frs_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/frs_seq.sv
// Operation sequencer: clearing pass, tree update walk, prefix sum and select descent.
// Depends on frs_pkg and instantiates frs_mem.
`timescale 1ns / 1ps
`default_nettype none

module frs_seq
    import frs_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    output logic        o_req_ready,
    input  wire t_req   i_req,
    output logic        o_res_valid,
    input  wire         i_res_ready,
    output t_res        o_res
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int IDX_X  = IDX_W + 1;
    localparam logic [IDX_W:0]    SLOTS_X  = IDX_X'(SLOTS);
    localparam logic [IDX_W-1:0]  SLOTS_I  = IDX_W'(SLOTS);
    localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0]  TOP_STEP = IDX_W'(1) << (IDX_W - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]    r_pop, n_pop;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_step, n_step;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]    r_sum, n_sum;
    logic                r_want, n_want;
    logic                r_first, n_first;
    t_res                r_res, n_res;

    logic                s_wr_en;
    logic [ADDR_W-1:0]   s_wr_addr;
    logic [WORD_W-1:0]   s_wr_data;
    logic                s_rd_en;
    logic [ADDR_W-1:0]   s_rd_addr;
    logic [WORD_W-1:0]   s_rd_data;

    logic [CNT_W-1:0]    s_cnt;
    logic                s_pres;
    logic [IDX_W-1:0]    s_low;
    logic [IDX_W:0]      s_up_next;
    logic [IDX_W:0]      s_nxt;
    logic [ADDR_W-1:0]   s_idx_addr;
    logic                s_key_ok;

    frs_mem #(
        .DEPTH (SLOTS),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    assign s_cnt      = s_rd_data[CNT_W-1:0];
    assign s_pres     = s_rd_data[CNT_W];
    assign s_low      = r_idx & (~r_idx + IDX_W'(1));
    assign s_up_next  = {1'b0, r_idx} + {1'b0, s_low};
    assign s_nxt      = {1'b0, r_pos} + {1'b0, r_step};
    assign s_idx_addr = ADDR_W'(r_idx - IDX_W'(1));
    assign s_key_ok   = (32'(i_req.key_slot) < 32'(SLOTS));

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_pop      = r_pop;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_step     = r_step;
        n_rem      = r_rem;
        n_sum      = r_sum;
        n_want     = r_want;
        n_first    = r_first;
        n_res      = r_res;
        s_wr_en    = 1'b0;
        s_wr_addr  = '0;
        s_wr_data  = '0;
        s_rd_en    = 1'b0;
        s_rd_addr  = '0;

        case (r_state)
            ST_CLEAR: begin
                s_wr_en   = 1'b1;
                s_wr_addr = r_clr_addr;
                if (r_clr_addr == LAST_A) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.func)
                        FN_INSERT, FN_DELETE: begin
                            n_want  = (i_req.func == FN_INSERT);
                            n_first = 1'b1;
                            n_idx   = IDX_W'(i_req.key_slot) + IDX_W'(1);
                            if (s_key_ok) begin
                                n_state = ST_UPD_RD;
                            end
                        end
                        FN_COUNT: begin
                            n_idx   = s_key_ok ? IDX_W'(i_req.key_slot) : SLOTS_I;
                            n_sum   = '0;
                            n_state = ST_SUM_RD;
                        end
                        FN_SELECT: begin
                            n_pos  = '0;
                            n_step = TOP_STEP;
                            n_rem  = i_req.order_k;
                            if (i_req.order_k == '0 || i_req.order_k > r_pop) begin
                                n_res   = '{below_count: '0, found_slot: '0, invalid: 1'b1};
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_SEL_RD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_UPD_RD: begin
                s_rd_en   = 1'b1;
                s_rd_addr = s_idx_addr;
                n_state   = ST_UPD_WR;
            end

            ST_UPD_WR: begin
                if (r_first && (s_pres == r_want)) begin
                    // Slot already in the requested state: nothing to do.
                    n_state = ST_IDLE;
                end else begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = s_idx_addr;
                    s_wr_data = {r_first ? r_want : s_pres,
                                 r_want ? s_cnt + CNT_W'(1) : s_cnt - CNT_W'(1)};
                    if (r_first) begin
                        n_pop = r_want ? r_pop + CNT_W'(1) : r_pop - CNT_W'(1);
                    end
                    n_first = 1'b0;
                    n_idx   = IDX_W'(s_up_next);
                    n_state = (s_up_next > SLOTS_X) ? ST_IDLE : ST_UPD_RD;
                end
            end

            ST_SUM_RD: begin
                if (r_idx == '0) begin
                    n_res   = '{below_count: r_sum, found_slot: '0, invalid: 1'b0};
                    n_state = ST_DONE;
                end else begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = s_idx_addr;
                    n_state   = ST_SUM_ACC;
                end
            end

            ST_SUM_ACC: begin
                n_sum   = r_sum + s_cnt;
                n_idx   = r_idx - s_low;
                n_state = ST_SUM_RD;
            end

            ST_SEL_RD: begin
                if (r_step == '0) begin
                    n_res   = '{below_count: '0, found_slot: KEY_W'(r_pos), invalid: 1'b0};
                    n_state = ST_DONE;
                end else if (s_nxt > SLOTS_X) begin
                    n_step = r_step >> 1;
                end else begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = ADDR_W'(s_nxt - IDX_X'(1));
                    n_state   = ST_SEL_CMP;
                end
            end

            ST_SEL_CMP: begin
                if (s_cnt < r_rem) begin
                    n_pos = IDX_W'(s_nxt);
                    n_rem = r_rem - s_cnt;
                end
                n_step  = r_step >> 1;
                n_state = ST_SEL_RD;
            end

            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_pop      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pop      <= n_pop;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_sum   <= n_sum;
        r_want  <= n_want;
        r_first <= n_first;
        r_res   <= n_res;
    end

endmodule

`default_nettype wire

FILE: sv/fenwick_rank_select_set_top.sv
// Top level of the Fenwick rank/select set: stream ports and the result register.
// Depends on frs_pkg and instantiates frs_seq (which holds frs_mem).
//
// An order-statistic set over SLOTS key slots. Each slot has a presence bit, and a
// binary indexed tree of counts lives beside it in one synchronous RAM word per slot.
// The operation code travels on tuser: insert and delete give no result beat (also when
// the slot is already in the asked state, or lies outside the domain), count returns
// the number of present slots strictly below the key, and select returns the slot of
// the k-th smallest present key or raises the invalid flag on tuser when k is zero or
// larger than the population. After reset the block sweeps the RAM to zero and accepts
// no beat until that pass is over. One operation is in the sequencer at a time; each
// visited tree entry is handled as a memory read, then a modify and write back (update),
// an accumulate (count) or a compare (select). A finished result waits in the output
// register, so the next beat is accepted while it is stalled.
`timescale 1ns / 1ps
`default_nettype none

module fenwick_rank_select_set_top
    import frs_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,   // key_slot [9:0], order_k [20:10], zero fill
    input  wire  [1:0]  i_s_axis_tuser,   // func [1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // below_count [10:0], found_slot [20:11], zero fill
    output logic        o_m_axis_tuser    // invalid [0]
);

    t_req  s_req;
    t_res  s_res;
    logic  s_res_valid;
    logic  s_res_ready;

    logic  r_out_valid;
    t_res  r_out;

    // Unpack the incoming beat into a request record.
    assign s_req.func     = t_func'(i_s_axis_tuser);
    assign s_req.key_slot = i_s_axis_tdata[KEY_W-1:0];
    assign s_req.order_k  = i_s_axis_tdata[KEY_W+CNT_W-1:KEY_W];

    frs_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (s_req),
        .o_res_valid (s_res_valid),
        .i_res_ready (s_res_ready),
        .o_res       (s_res)
    );

    // The output register takes a new result when it is empty or being emptied.
    assign s_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_valid && s_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s_res_valid && s_res_ready) begin
            r_out <= s_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.found_slot, r_out.below_count};
    assign o_m_axis_tuser  = r_out.invalid;

    // An invalid select carries neither a count nor a slot.
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 24'd0)
        else $error("invalid result carries non-zero data");

    // The clearing pass blocks input in the cycle after reset.
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input accepted during clearing pass");

    // A result handed over by the sequencer is presented on the next cycle.
    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid && s_res_ready |=> o_m_axis_tvalid)
        else $error("result lost between sequencer and output register");

endmodule

`default_nettype wire
